// ===== hw/rtl/integer_to_ascii_formatter_defines.svh =====
// assertion macros for the integer to ascii formatter checker
// depends on nothing, expects clk_i and rst_ni in the including scope
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define I2A_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2a assertion failed");

// next-cycle implication, disabled during reset
`define I2A_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2a assertion failed");

`endif

// ===== hw/rtl/i2a_pkg.sv =====
// shared types, constants and helpers of the integer to ascii formatter
// depends on nothing
`timescale 1ns / 1ps

package i2a_pkg;

  localparam int NUMBER_W           = 64;
  localparam int MIN_DIGITS_W       = 6;
  localparam int CHAR_W             = 8;
  localparam int VALUE_BITS_DEF     = 64;
  localparam int MAX_MIN_DIGITS_DEF = 32;
  localparam int STORE_DEPTH_DEF    = 34;
  localparam int BIN_SLOTS          = 32;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_BIN = 2'd2
  } radix_e;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_B     = 8'h62;
  localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;

  // control from the sequencer to the digit unit
  typedef struct packed {
    logic   load;
    logic   dabble;
    logic   shift;
    logic   neg;
    radix_e radix;
  } du_ctrl_t;

  // decimal digits needed for a value of the given width (1233/4096 ~ log10 2)
  function automatic int dec_digits(input int bits);
    return ((bits * 1233) >> 12) + 1;
  endfunction

  function automatic int hex_digits(input int bits);
    return (bits + 3) >> 2;
  endfunction

  function automatic int max3(input int a, input int b, input int c);
    int m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d, input logic up);
    logic [CHAR_W-1:0] base;
    base = up ? CHAR_UA : CHAR_LA;
    if (d < 4'd10) begin
      return CHAR_ZERO + {4'b0, d};
    end
    return base + {4'b0, d} - 8'd10;
  endfunction

endpackage

// ===== hw/rtl/i2a_digit_unit.sv =====
// digit unit: magnitude shift register and top-aligned digit register
// depends on i2a_pkg
`timescale 1ns / 1ps

module i2a_digit_unit #(
  parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic [i2a_pkg::NUMBER_W-1:0]  number_i,
  input  i2a_pkg::du_ctrl_t             ctrl_i,
  output logic [3:0]                    digit_o
);
  import i2a_pkg::*;

  localparam int NDIG = dec_digits(VALUE_BITS);
  localparam int HEXD = hex_digits(VALUE_BITS);
  localparam int WW   = max3(4 * NDIG, 4 * HEXD, BIN_SLOTS);

  logic [VALUE_BITS-1:0] value;
  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [WW-1:0]         work_q, work_d;
  logic [4*NDIG-1:0]     bcd, adj, bcd_sh;

  assign value = number_i[VALUE_BITS-1:0];

  // add-3 correction on every bcd digit, then shift in the next magnitude bit
  always_comb begin
    bcd = work_q[WW-1 -: 4*NDIG];
    for (int i = 0; i < NDIG; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
    bcd_sh = {adj[4*NDIG-2:0], mag_q[VALUE_BITS-1]};
  end

  always_comb begin
    mag_d  = mag_q;
    work_d = work_q;
    if (ctrl_i.load) begin
      mag_d  = ctrl_i.neg ? VALUE_BITS'(~value + 1'b1) : value;
      case (ctrl_i.radix)
        RADIX_HEX: work_d = WW'(value) << (WW - 4 * HEXD);
        RADIX_BIN: work_d = WW'(32'(value)) << (WW - BIN_SLOTS);
        default:   work_d = '0;
      endcase
    end else if (ctrl_i.dabble) begin
      mag_d  = mag_q << 1;
      work_d = WW'(bcd_sh) << (WW - 4 * NDIG);
    end else if (ctrl_i.shift) begin
      work_d = (ctrl_i.radix == RADIX_BIN) ? work_q << 1 : work_q << 4;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    work_q <= work_d;
  end

  assign digit_o = (ctrl_i.radix == RADIX_BIN) ? {3'b000, work_q[WW-1]} : work_q[WW-1 -: 4];

endmodule

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// channel  dir  fields                                          handshake
// in       in   number radix is_signed min_digits with_prefix     in_valid_i / in_ready_o
//               upper_case
// out      out  character last                                  out_valid_o / out_ready_i
//
// one item at a time: no new item is taken until the last beat of the current one has gone
// decimal: accept, double dabble over all VALUE_BITS bits, then skip each dropped leading zero
// digit, then a length step and the characters
// hex and binary skip the dabble: leading zero digits are skipped, then length and characters
// leading characters beyond the last STORE_DEPTH are not shown and give no beat; a stall holds the beat
// reset is asynchronous, active low, and leaves the block idle and ready
// top level of the integer to ascii formatter
// depends on i2a_pkg and i2a_digit_unit
`timescale 1ns / 1ps

module integer_to_ascii_formatter #(
  parameter int VALUE_BITS     = i2a_pkg::VALUE_BITS_DEF,
  parameter int MAX_MIN_DIGITS = i2a_pkg::MAX_MIN_DIGITS_DEF,
  parameter int STORE_DEPTH    = i2a_pkg::STORE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [i2a_pkg::NUMBER_W-1:0]     number_i,
  input  logic [1:0]                       radix_i,
  input  logic                             is_signed_i,
  input  logic [i2a_pkg::MIN_DIGITS_W-1:0] min_digits_i,
  input  logic                             with_prefix_i,
  input  logic                             upper_case_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [i2a_pkg::CHAR_W-1:0]       character_o,
  output logic                             last_o
);
  import i2a_pkg::*;

  localparam int NDIG    = dec_digits(VALUE_BITS);
  localparam int HEXD    = hex_digits(VALUE_BITS);
  localparam int MAXS    = max3(NDIG, HEXD, BIN_SLOTS);
  localparam int SLOT_W  = $clog2(MAXS + 1);
  // longest string: padded digits plus a two character prefix
  localparam int MAXLEN  = ((MAX_MIN_DIGITS > BIN_SLOTS) ? MAX_MIN_DIGITS : BIN_SLOTS) + 2;
  localparam int LEN_W   = $clog2(MAXLEN + 1);
  localparam int CNT_W   = $clog2(VALUE_BITS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DABBLE = 3'd1;
  localparam logic [2:0] ST_SKIP   = 3'd2;
  localparam logic [2:0] ST_CALC   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]        state_q, state_d;
  radix_e            radix_q, radix_d;
  logic              neg_q, neg_d;
  logic              upper_q, upper_d;
  logic              prefix_q, prefix_d;
  logic [LEN_W-1:0]  min_q, min_d;
  logic [CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic [SLOT_W-1:0] slots_q, slots_d;
  logic [1:0]        pre_q, pre_d;
  logic [LEN_W-1:0]  pad_q, pad_d;
  logic [LEN_W-1:0]  drop_q, drop_d;

  du_ctrl_t          ctrl;
  logic [3:0]        digit;
  logic              in_fire;
  logic              step;
  radix_e            radix_in;
  logic [LEN_W-1:0]  min_in;
  logic [LEN_W-1:0]  nd, pad_v, len_v;
  logic [1:0]        pre_v;

  assign radix_in   = radix_e'(radix_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  // dropped leading characters walk past without a beat
  assign out_valid_o = (state_q == ST_EMIT) && (drop_q == '0);
  assign step        = (state_q == ST_EMIT) && ((drop_q != '0) || out_ready_i);

  // minimum digit count saturates
  assign min_in = (LEN_W'(min_digits_i) > LEN_W'(MAX_MIN_DIGITS)) ?
                  LEN_W'(MAX_MIN_DIGITS) : LEN_W'(min_digits_i);

  // string length: sign or prefix, zero padding, significant digits
  always_comb begin
    nd    = LEN_W'(slots_q);
    pad_v = ((radix_q != RADIX_DEC) && (min_q > nd)) ? min_q - nd : '0;
    if (radix_q == RADIX_DEC) begin
      pre_v = {1'b0, neg_q};
    end else begin
      pre_v = prefix_q ? 2'd2 : 2'd0;
    end
    len_v = LEN_W'(pre_v) + pad_v + nd;
  end

  always_comb begin
    state_d     = state_q;
    radix_d     = radix_q;
    neg_d       = neg_q;
    upper_d     = upper_q;
    prefix_d    = prefix_q;
    min_d       = min_q;
    bit_cnt_d   = bit_cnt_q;
    slots_d     = slots_q;
    pre_d       = pre_q;
    pad_d       = pad_q;
    drop_d      = drop_q;
    ctrl        = '0;
    ctrl.radix  = radix_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ctrl.load  = 1'b1;
          ctrl.radix = radix_in;
          ctrl.neg   = (radix_in == RADIX_DEC) && is_signed_i && number_i[VALUE_BITS-1];
          radix_d    = radix_in;
          neg_d      = ctrl.neg;
          upper_d    = upper_case_i;
          prefix_d   = with_prefix_i;
          min_d      = min_in;
          case (radix_in)
            RADIX_DEC: begin
              state_d   = ST_DABBLE;
              slots_d   = SLOT_W'(NDIG);
              bit_cnt_d = CNT_W'(VALUE_BITS);
            end
            RADIX_HEX: begin
              state_d = ST_SKIP;
              slots_d = SLOT_W'(HEXD);
            end
            RADIX_BIN: begin
              state_d = ST_SKIP;
              slots_d = SLOT_W'(BIN_SLOTS);
            end
            default: state_d = ST_IDLE;  // unused radix gives no beats
          endcase
        end
      end
      ST_DABBLE: begin
        ctrl.dabble = 1'b1;
        bit_cnt_d   = bit_cnt_q - 1'b1;
        if (bit_cnt_q == CNT_W'(1)) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zero digits, keep at least one
        if ((slots_q > SLOT_W'(1)) && (digit == 4'd0)) begin
          ctrl.shift = 1'b1;
          slots_d    = slots_q - 1'b1;
        end else begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        pre_d   = pre_v;
        pad_d   = pad_v;
        drop_d  = (int'(len_v) > STORE_DEPTH) ? LEN_W'(int'(len_v) - STORE_DEPTH) : '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (step) begin
          if (drop_q != '0) begin
            drop_d = drop_q - 1'b1;
          end
          if (pre_q != 2'd0) begin
            pre_d = pre_q - 1'b1;
          end else if (pad_q != '0) begin
            pad_d = pad_q - 1'b1;
          end else if (slots_q == SLOT_W'(1)) begin
            state_d = ST_IDLE;
          end else begin
            ctrl.shift = 1'b1;
            slots_d    = slots_q - 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      radix_q   <= RADIX_DEC;
      neg_q     <= 1'b0;
      upper_q   <= 1'b0;
      prefix_q  <= 1'b0;
      min_q     <= '0;
      bit_cnt_q <= '0;
      slots_q   <= '0;
      pre_q     <= '0;
      pad_q     <= '0;
      drop_q    <= '0;
    end else begin
      state_q   <= state_d;
      radix_q   <= radix_d;
      neg_q     <= neg_d;
      upper_q   <= upper_d;
      prefix_q  <= prefix_d;
      min_q     <= min_d;
      bit_cnt_q <= bit_cnt_d;
      slots_q   <= slots_d;
      pre_q     <= pre_d;
      pad_q     <= pad_d;
      drop_q    <= drop_d;
    end
  end

  i2a_digit_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_digit (
    .clk_i   (clk_i),
    .number_i(number_i),
    .ctrl_i  (ctrl),
    .digit_o (digit)
  );

  // character of the current position: sign or prefix, padding, then digits
  always_comb begin
    if (pre_q != 2'd0) begin
      if (radix_q == RADIX_DEC) begin
        character_o = CHAR_MINUS;
      end else if (pre_q == 2'd2) begin
        character_o = CHAR_ZERO;
      end else begin
        character_o = (radix_q == RADIX_HEX) ? CHAR_X : CHAR_B;
      end
    end else if (pad_q != '0) begin
      character_o = CHAR_ZERO;
    end else begin
      character_o = hex_char(digit, upper_q);
    end
  end

  assign last_o = (pre_q == 2'd0) && (pad_q == '0) && (slots_q == SLOT_W'(1));

endmodule

// ===== hw/rtl/i2a_checker.sv =====
// port-level checker for the integer to ascii formatter, bound to the top
// depends on integer_to_ascii_formatter_defines.svh and i2a_pkg
`timescale 1ns / 1ps
`include "integer_to_ascii_formatter_defines.svh"

module i2a_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic [i2a_pkg::NUMBER_W-1:0]     number_i,
  input logic [1:0]                       radix_i,
  input logic                             is_signed_i,
  input logic [i2a_pkg::MIN_DIGITS_W-1:0] min_digits_i,
  input logic                             with_prefix_i,
  input logic                             upper_case_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [i2a_pkg::CHAR_W-1:0]       character_o,
  input logic                             last_o
);
  import i2a_pkg::*;

  logic in_beat, out_beat, valid_radix;

  assign in_beat     = in_valid_i && in_ready_o;
  assign out_beat    = out_valid_o && out_ready_i;
  assign valid_radix = (radix_i == RADIX_DEC) || (radix_i == RADIX_HEX) ||
                       (radix_i == RADIX_BIN);

  // one item in flight: no beat is shown while a new item may enter
  `I2A_ASSERT_NOW(a_ready_excl, in_ready_o, !out_valid_o)
  // a formatted item holds off the input side
  `I2A_ASSERT_NEXT(a_busy_after_in, in_beat && valid_radix, !in_ready_o)
  // the last beat frees the block
  `I2A_ASSERT_NEXT(a_idle_after_last, out_beat && last_o, in_ready_o && !out_valid_o)
  // a stalled beat keeps its character
  `I2A_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(character_o) && $stable(last_o))

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (.*);
